FILE: sv/crc16c_pkg.sv
// ============================================================================
// CRC-16 CCITT shift-in package
// Constants and the byte update function for the augmented CCITT register.
// ============================================================================
`default_nettype none

package crc16c_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef logic [BYTE_W-1:0] byte_data_t;
    typedef logic [CRC_W-1:0]  crc_t;

    // Shifts one byte into the register, most significant bit first. Each bit
    // step moves the message bit into bit 0 and folds in the polynomial when
    // the bit that dropped out of the top was set.
    function automatic crc_t crc_shift_byte(input crc_t crc_in, input byte_data_t data);
        crc_t crc;
        logic out_bit;
        crc = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            out_bit = crc[CRC_W-1];
            crc     = {crc[CRC_W-2:0], data[i]};
            if (out_bit) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: sv/crc16_ccitt_shift_in_core.sv
// ============================================================================
// CRC-16 CCITT shift-in core
// Running augmented CCITT CRC over a byte stream, one result per byte.
// ============================================================================
//
// Channel   Dir  Transfer              Contents
// s_        in   s_tvalid & s_tready   tdata: data_byte, tuser: start_of_message,
//                                      tlast: last_byte
// m_        out  m_tvalid & m_tready   tdata: crc_value, tlast: is_final
//
// One byte is taken every cycle while the result side keeps up; the limit is
// the eight XOR bit steps between the input register and the CRC register.
// A result passes through the input register, then the result register. When
// the result side stalls, the input register still takes one more byte, after
// which s_tready drops until the stall clears.
// Reset clears the CRC register to zero and empties both stages.
`default_nettype none

module crc16_ccitt_shift_in_core
    import crc16c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_message
    input  wire logic        s_tlast,   // last_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] crc_value
    output logic             m_tlast    // is_final
);

    // Input stage: holds one accepted byte until the result stage can take it.
    logic       in_valid_reg;
    logic       in_valid_next;
    byte_data_t in_data_reg;
    logic       in_start_reg;
    logic       in_last_reg;

    // Running register state. It moves only when a byte passes into the
    // result stage, so a stalled result holds it where it is.
    crc_t crc_reg;
    crc_t crc_next;

    // Result stage.
    logic out_valid_reg;
    logic out_valid_next;
    crc_t out_crc_reg;
    logic out_last_reg;

    logic out_free;
    logic advance;
    logic s_xfer;
    crc_t crc_base;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    // A start flag clears the register before its byte is shifted in.
    assign crc_base = in_start_reg ? '0 : crc_reg;
    assign crc_next = crc_shift_byte(crc_base, in_data_reg);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                crc_reg <= crc_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance) begin
            out_crc_reg  <= crc_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;
    assign m_tlast  = out_last_reg;

    // The result just loaded always matches the running register.
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tdata == crc_reg))
        else $error("result register differs from running CRC state");

    // A byte held in the input stage during a result stall is kept intact.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)
                                        && $stable(in_start_reg)))
        else $error("input stage lost or changed a waiting byte");

    // The running state only moves when a byte passes into the result stage.
    a_state_moves_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(crc_reg))
        else $error("CRC state changed without a byte");

    // Reset leaves both stages empty and the register cleared.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg && (crc_reg == '0)))
        else $error("reset did not clear the pipeline");

endmodule

`default_nettype wire
